>>> sv/nbfr_pkg.sv
// ----------------------------------------------------------------------------
// nbfr_pkg - nine-bit frame receiver package
// Transfer types, route and status codes, frame type decode.
// ----------------------------------------------------------------------------
package nbfr_pkg;

  localparam int FRAME_LIMIT_DEFAULT = 16;

  typedef enum logic [1:0] {
    ROUTE_NONE   = 2'd0,
    ROUTE_ANSWER = 2'd1,
    ROUTE_DATA   = 2'd2,
    ROUTE_EVENT  = 2'd3
  } route_t;

  typedef enum logic [2:0] {
    STAT_NONE      = 3'd0,
    STAT_GOOD      = 3'd1,
    STAT_MISMATCH  = 3'd2,
    STAT_NO_START  = 3'd3,
    STAT_DROPPED   = 3'd4
  } status_t;

  // frame type flags: bit 0 answer, bit 1 event, bit 2 foreign interrupt
  localparam logic [2:0] FT_ANSWER  = 3'b001;
  localparam logic [2:0] FT_EVENT   = 3'b010;
  localparam logic [2:0] FT_FOREIGN = 3'b100;

  localparam logic [7:0] START_BIT = 8'h80;

  typedef struct packed {
    logic       control_flag;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    route_t     route;
    logic [7:0] routed_byte;
    status_t    frame_status;
    logic       answer_ready;
    logic       event_ready;
    logic [7:0] computed_checksum;
  } out_item_t;

  function automatic logic [2:0] frame_type(input logic [7:0] b);
    logic [2:0] t;
    t = 3'b000;
    if (b[6]) begin
      t = FT_ANSWER;
    end else if (b[3]) begin
      if (b[4]) t = t | FT_FOREIGN;
      if (b[5]) t = t | FT_EVENT;
    end else begin
      t = FT_EVENT;
    end
    return t;
  endfunction

endpackage

>>> sv/nbfr_core.sv
// ----------------------------------------------------------------------------
// nbfr_core - frame state and per-word decode
// Holds frame position, start byte, running checksum and seed; computes the
// result for the current word in one pass.
// ----------------------------------------------------------------------------
module nbfr_core #(
  parameter int FRAME_LIMIT = nbfr_pkg::FRAME_LIMIT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                accept,
  input  nbfr_pkg::in_item_t  item,
  output nbfr_pkg::out_item_t result
);

  localparam int PW = (FRAME_LIMIT > 2) ? $clog2(FRAME_LIMIT) : 1;
  localparam logic [PW-1:0] POS_LAST = PW'(FRAME_LIMIT - 1);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    seed_r;
  logic [7:0]    csum_fin;
  logic [2:0]    ftype;
  logic [2:0]    ftype_new;

  assign csum_fin  = sum_r[7] ? ~sum_r : sum_r;
  assign ftype     = nbfr_pkg::frame_type(first_r);
  assign ftype_new = nbfr_pkg::frame_type(item.byte_value);

  always_comb begin
    pos_nxt   = pos_r;
    first_nxt = first_r;
    sum_nxt   = sum_r;
    result    = '0;
    if (item.control_flag) begin
      if ((item.byte_value & nbfr_pkg::START_BIT) != 8'h00) begin
        first_nxt = item.byte_value;
        sum_nxt   = item.byte_value - seed_r;
        pos_nxt   = PW'(1);
        if (ftype_new == nbfr_pkg::FT_ANSWER) begin
          result.route = nbfr_pkg::ROUTE_ANSWER;
        end else if (ftype_new == nbfr_pkg::FT_EVENT) begin
          result.route = nbfr_pkg::ROUTE_EVENT;
        end
      end else if (pos_r != '0) begin
        result.computed_checksum = csum_fin;
        if (csum_fin == item.byte_value) begin
          result.frame_status = nbfr_pkg::STAT_GOOD;
          result.answer_ready = ftype[0];
          result.event_ready  = ftype[1];
        end else begin
          result.frame_status = nbfr_pkg::STAT_MISMATCH;
        end
        pos_nxt = '0;
      end else begin
        result.frame_status = nbfr_pkg::STAT_NO_START;
        pos_nxt = '0;
      end
    end else begin
      if (pos_r != '0 && pos_r < POS_LAST) begin
        // rotate left with carry-in of the old top bit, then subtract
        sum_nxt = {sum_r[6:0], 1'b0} - item.byte_value + {7'd0, sum_r[7]};
        pos_nxt = pos_r + PW'(1);
        // payload always sits past the start byte
        if (ftype == nbfr_pkg::FT_ANSWER) begin
          result.route = nbfr_pkg::ROUTE_DATA;
        end else if (ftype == nbfr_pkg::FT_EVENT) begin
          result.route = nbfr_pkg::ROUTE_EVENT;
        end
      end else begin
        result.frame_status = nbfr_pkg::STAT_DROPPED;
        pos_nxt = '0;
      end
    end
    if (result.route != nbfr_pkg::ROUTE_NONE) begin
      result.routed_byte = item.byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seed_r <= '0;
    end else begin
      if (cfg_wr_en) seed_r <= cfg_wr_data;
      if (accept)    pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= first_nxt;
      sum_r   <= sum_nxt;
    end
  end

endmodule

>>> sv/nbfr_out_stage.sv
// ----------------------------------------------------------------------------
// nbfr_out_stage - result register
// Holds one result until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module nbfr_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  nbfr_pkg::out_item_t load_data,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output nbfr_pkg::out_item_t out_data
);

  logic                out_valid_r, out_valid_nxt;
  nbfr_pkg::out_item_t out_data_r;

  // a held result blocks new loads only while the sink stalls
  assign busy = out_valid_r & out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= load_data;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/nine_bit_frame_receiver.sv
// ----------------------------------------------------------------------------
// nine_bit_frame_receiver - nine-bit link frame receiver
// Takes one link word per cycle while in_stall is low and gives one result per
// word: a start word (ninth bit and bit 7 set) opens a frame, plain words are
// payload, other control words close an open frame with a checksum check. Each
// accepted word's result is registered in the cycle after its input transfer;
// the word rate is bounded by the checksum update on the running sum register.
// Input stall rises only while a result is held and the sink stalls. The
// checksum seed is written through cfg_wr_en/cfg_wr_data.
// ----------------------------------------------------------------------------
module nine_bit_frame_receiver #(
  parameter int FRAME_LIMIT = nbfr_pkg::FRAME_LIMIT_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  nbfr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nbfr_pkg::out_item_t out_data
);

  logic                accept;
  logic                busy;
  nbfr_pkg::out_item_t result;

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  nbfr_core #(
    .FRAME_LIMIT(FRAME_LIMIT)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .item       (in_data),
    .result     (result)
  );

  nbfr_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .load_data(result),
    .busy     (busy),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word left no result");

  a_held_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  a_ready_needs_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.answer_ready || out_data.event_ready)) |->
    (out_data.frame_status == nbfr_pkg::STAT_GOOD))
    else $error("ready flag without good checksum");

  a_route_excl_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.route != nbfr_pkg::ROUTE_NONE) |->
    (out_data.frame_status == nbfr_pkg::STAT_NONE && out_data.computed_checksum == 8'h00))
    else $error("routed byte with frame status");
`endif

endmodule
